/* rtl/kwg_pkg.sv */
// Shared types and constants for the Kaiser window coefficient generator.
package kwg_pkg;

  localparam int LEN_W   = 13;
  localparam int BETA_W  = 16;
  localparam int IDX_W   = 12;
  localparam int VAL_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;

  localparam int MAX_LENGTH = 4096;
  localparam int N_SERIES_TERMS = 40;
  localparam int LEN_CAP_I  = (MAX_LENGTH > 8191) ? 8191 : MAX_LENGTH;
  localparam logic [LEN_W-1:0]  LEN_CAP  = LEN_W'(LEN_CAP_I);
  localparam logic [BETA_W-1:0] BETA_MAX = 16'd49152;
  localparam logic [LEN_W-1:0]  LEN_RESET  = 13'd1025;
  localparam logic [BETA_W-1:0] BETA_RESET = 16'd20480;

  localparam int A_W    = 30;
  localparam int T_W    = 22;
  localparam int TERM_W = 63;
  localparam int DD_W   = 26;
  localparam int PROD_W = 56;
  localparam logic [A_W-1:0] PI2_Q28 = 30'd662337939;
  localparam logic [TERM_W-1:0] ONE_Q12 = 63'd4096;
  localparam logic [VAL_W-1:0] ONE_Q15 = 16'd32768;

  localparam int DIV_W = 80;
  localparam int REM_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA   = 1'b1;

  typedef enum logic [1:0] {
    TAG_TN    = 2'd0,
    TAG_NUM   = 2'd1,
    TAG_DEN   = 2'd2,
    TAG_RATIO = 2'd3
  } tag_t;

  typedef struct packed {
    logic             valid;
    tag_t             tag;
    logic [REM_W-1:0] rem;
    logic [DIV_W-1:0] dq;
    logic [REM_W-1:0] dvs;
  } div_beat_t;

endpackage

/* rtl/kwg_div_cell.sv */
// One restoring division step: fixes one quotient bit and hands the beat on.
module kwg_div_cell (
  input  logic               clk,
  input  logic               rst,
  input  kwg_pkg::div_beat_t beat_in,
  output kwg_pkg::div_beat_t beat_out
);
  import kwg_pkg::*;

  logic [REM_W-1:0] sh;
  logic [REM_W-1:0] diff;
  logic             ge;

  assign sh   = {beat_in.rem[REM_W-2:0], beat_in.dq[DIV_W-1]};
  assign ge   = (sh >= beat_in.dvs);
  assign diff = sh - beat_in.dvs;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_out.valid <= 1'b0;
    end else begin
      beat_out.valid <= beat_in.valid;
    end
    beat_out.tag <= beat_in.tag;
    beat_out.rem <= ge ? diff : sh;
    beat_out.dq  <= {beat_in.dq[DIV_W-2:0], ge};
    beat_out.dvs <= beat_in.dvs;
  end

endmodule

/* rtl/kaiser_window_generator.sv */
// Kaiser window generator: sequencer, series datapath and a row of divider cells.
// An index out of range or the middle of an odd window goes to done straight from the check
// state; any other index runs the series. Throughput: one item at a time; the next start
// beat can be taken at the edge that takes done. Each series term waits through the 80-cell
// divider row. The receiver cannot stall; busy drops as done rises.
// Reset (rst, synchronous) restores length 1025 and beta 5.0 and clears the sequencer.
module kaiser_window_generator #(
  parameter int SERIES_TERMS = kwg_pkg::N_SERIES_TERMS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [kwg_pkg::IDX_W-1:0]         sample_index,
  output logic                              done,
  output logic [kwg_pkg::VAL_W-1:0]         window_value,
  output logic                              index_out_of_range,
  input  logic                              cfg_write,
  input  logic [kwg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kwg_pkg::CFG_W-1:0]         cfg_data
);
  import kwg_pkg::*;

  localparam int KW    = $clog2(SERIES_TERMS);
  localparam int KSQ_W = 2 * KW;
  localparam logic [KW-1:0] LAST_K  = KW'(SERIES_TERMS - 1);
  localparam logic [KW-1:0] FIRST_K = KW'(2);

  typedef enum logic [13:0] {
    ST_IDLE    = 14'b00000000000001,
    ST_CHECK   = 14'b00000000000010,
    ST_SQR     = 14'b00000000000100,
    ST_SCALE   = 14'b00000000001000,
    ST_ROUND   = 14'b00000000010000,
    ST_ARG     = 14'b00000000100000,
    ST_TNDIV   = 14'b00000001000000,
    ST_TNWAIT  = 14'b00000010000000,
    ST_MUL     = 14'b00000100000000,
    ST_ISS_NUM = 14'b00001000000000,
    ST_ISS_DEN = 14'b00010000000000,
    ST_TWAIT   = 14'b00100000000000,
    ST_RATIO   = 14'b01000000000000,
    ST_RWAIT   = 14'b10000000000000
  } state_t;

  state_t state;

  logic [LEN_W-1:0]  window_length;
  logic [BETA_W-1:0] shape_beta;

  logic [IDX_W-1:0]  n;
  logic [LEN_W-1:0]  d;
  logic [LEN_W-1:0]  m;
  logic [BETA_W-1:0] beta;
  logic [31:0]       b2;
  logic [DD_W-1:0]   dd;
  logic [DD_W-1:0]   md4;
  logic [61:0]       p;
  logic [A_W-1:0]    a;
  logic [PROD_W-1:0] prod;
  logic [T_W-1:0]    tf;
  logic [T_W-1:0]    tn;
  logic [TERM_W-1:0] num_sum;
  logic [TERM_W-1:0] num_term;
  logic [TERM_W-1:0] den_sum;
  logic [TERM_W-1:0] den_term;
  logic [53:0]       pl_n;
  logic [52:0]       ph_n;
  logic [53:0]       pl_d;
  logic [52:0]       ph_d;
  logic [KW-1:0]     k;

  logic [LEN_W-1:0]  len_e;
  logic [LEN_W-1:0]  n_ext;
  logic [LEN_W-1:0]  d_c;
  logic [KSQ_W-1:0]  ksq;
  logic [TERM_W-1:0] q_term;
  logic [17:0]       q_round;

  div_beat_t issue;
  div_beat_t chain [DIV_W+1];
  div_beat_t res;

  assign busy  = (state != ST_IDLE);
  assign len_e = (window_length > LEN_CAP) ? LEN_CAP : window_length;
  assign n_ext = LEN_W'(n);
  assign d_c   = len_e - LEN_W'(1);
  assign ksq   = KSQ_W'(k) * KSQ_W'(k);
  assign res   = chain[DIV_W];
  assign q_term  = res.dq[TERM_W-1:0];
  assign q_round = (18'(res.dq[16:0]) + 18'd1) >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= LEN_RESET;
      shape_beta    <= BETA_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_LENGTH: window_length <= cfg_data[LEN_W-1:0];
        CFG_BETA:   shape_beta    <= cfg_data;
      endcase
    end
  end

  always_comb begin
    issue       = '0;
    issue.tag   = TAG_TN;
    unique case (state)
      ST_TNDIV: begin
        issue.valid = 1'b1;
        issue.tag   = TAG_TN;
        issue.dq    = DIV_W'((57'(prod) + (57'(dd) << 7)) >> 8);
        issue.dvs   = REM_W'(dd);
      end
      ST_ISS_NUM: begin
        issue.valid = 1'b1;
        issue.tag   = TAG_NUM;
        issue.dq    = DIV_W'(((85'(ph_n) << 32) + 85'(pl_n)) >> 12);
        issue.dvs   = REM_W'(ksq);
      end
      ST_ISS_DEN: begin
        issue.valid = 1'b1;
        issue.tag   = TAG_DEN;
        issue.dq    = DIV_W'(((85'(ph_d) << 32) + 85'(pl_d)) >> 12);
        issue.dvs   = REM_W'(ksq);
      end
      ST_RATIO: begin
        issue.valid = 1'b1;
        issue.tag   = TAG_RATIO;
        issue.dq    = DIV_W'(num_sum) << 16;
        issue.dvs   = REM_W'(den_sum);
      end
      default: begin
        issue.valid = 1'b0;
      end
    endcase
  end

  assign chain[0] = issue;

  for (genvar i = 0; i < DIV_W; i++) begin : g_cell
    kwg_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .beat_in  (chain[i]),
      .beat_out (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (n_ext >= len_e) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else if (len_e[0] && n_ext == (d_c >> 1)) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            state <= ST_SQR;
          end
        end
        ST_SQR:     state <= ST_SCALE;
        ST_SCALE:   state <= ST_ROUND;
        ST_ROUND:   state <= ST_ARG;
        ST_ARG:     state <= ST_TNDIV;
        ST_TNDIV:   state <= ST_TNWAIT;
        ST_TNWAIT: begin
          if (res.valid && res.tag == TAG_TN) begin
            state <= ST_MUL;
          end
        end
        ST_MUL:     state <= ST_ISS_NUM;
        ST_ISS_NUM: state <= ST_ISS_DEN;
        ST_ISS_DEN: state <= ST_TWAIT;
        ST_TWAIT: begin
          if (res.valid && res.tag == TAG_DEN) begin
            state <= (k == LAST_K) ? ST_RATIO : ST_MUL;
          end
        end
        ST_RATIO:   state <= ST_RWAIT;
        ST_RWAIT: begin
          if (res.valid && res.tag == TAG_RATIO) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default:    state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        n <= sample_index;
      end
      ST_CHECK: begin
        beta <= (shape_beta > BETA_MAX) ? BETA_MAX : shape_beta;
        d    <= d_c;
        m    <= (n_ext < (len_e >> 1)) ? n_ext : d_c - n_ext;
        if (n_ext >= len_e) begin
          window_value       <= '0;
          index_out_of_range <= 1'b1;
        end else begin
          window_value       <= ONE_Q15;
          index_out_of_range <= 1'b0;
        end
      end
      ST_SQR: begin
        b2  <= 32'(beta) * 32'(beta);
        dd  <= DD_W'(d) * DD_W'(d);
        md4 <= (DD_W'(m) * DD_W'(d - m)) << 2;
      end
      ST_SCALE: begin
        p <= 62'(b2) * 62'(PI2_Q28);
      end
      ST_ROUND: begin
        a <= A_W'((63'(p) + (63'(1) << 31)) >> 32);
      end
      ST_ARG: begin
        prod <= PROD_W'(a) * PROD_W'(md4);
        tf   <= T_W'((31'(a) + 31'd128) >> 8);
      end
      ST_TNWAIT: begin
        if (res.valid && res.tag == TAG_TN) begin
          tn       <= res.dq[T_W-1:0];
          num_sum  <= ONE_Q12 + TERM_W'(res.dq[T_W-1:0]);
          num_term <= TERM_W'(res.dq[T_W-1:0]);
          den_sum  <= ONE_Q12 + TERM_W'(tf);
          den_term <= TERM_W'(tf);
          k        <= FIRST_K;
        end
      end
      ST_MUL: begin
        pl_n <= 54'(num_term[31:0]) * 54'(tn);
        ph_n <= 53'(num_term[TERM_W-1:32]) * 53'(tn);
        pl_d <= 54'(den_term[31:0]) * 54'(tf);
        ph_d <= 53'(den_term[TERM_W-1:32]) * 53'(tf);
      end
      ST_TWAIT: begin
        if (res.valid && res.tag == TAG_NUM) begin
          num_term <= q_term;
          num_sum  <= num_sum + q_term;
        end
        if (res.valid && res.tag == TAG_DEN) begin
          den_term <= q_term;
          den_sum  <= den_sum + q_term;
          k        <= k + KW'(1);
        end
      end
      ST_RWAIT: begin
        if (res.valid && res.tag == TAG_RATIO) begin
          window_value       <= (q_round > 18'(ONE_Q15)) ? ONE_Q15 : q_round[VAL_W-1:0];
          index_out_of_range <= 1'b0;
        end
      end
      default: begin
        n <= n;
      end
    endcase
  end

endmodule
